// File: src/sphc_pkg.sv
// ----------------------------------------------------------------------------
// sphc_pkg
// Types and constants shared by the space packet header checker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sphc_pkg;

    // Primary header size and fixed length overhead
    localparam int unsigned HDR_BYTES     = 6;
    localparam logic [16:0] HDR_BYTES_17  = 17'd6;
    localparam logic [16:0] OVERHEAD_17   = 17'd7;
    localparam int unsigned SEC_FLAG_BIT  = 3;
    localparam logic [16:0] COUNT_MAX     = 17'h1FFFF;

    // Time code bytes that the decoder looks at
    localparam int unsigned TC_READ_BYTES = 9;

    // Configuration register indexes
    localparam logic [1:0] CFG_SEC_HEADER_LENGTH = 2'd0;
    localparam logic [1:0] CFG_TIME_CODE_LENGTH  = 2'd1;
    localparam logic [1:0] CFG_TIME_CODE_FORMAT  = 2'd2;

    // Time code formats
    localparam logic [3:0] FMT_CUC_FIRST = 4'd1;
    localparam logic [3:0] FMT_CUC_LAST  = 4'd8;
    localparam logic [3:0] FMT_CUC_L2    = 4'd5;
    localparam logic [3:0] FMT_CDS_SHORT = 4'd9;
    localparam logic [3:0] FMT_CDS_LONG  = 4'd10;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TOO_SMALL    = 3'd1,
        ST_LEN_MISMATCH = 3'd2,
        ST_CFG_INVALID  = 3'd3,
        ST_SEC_OVERSIZE = 3'd4
    } status_t;

    typedef logic [TC_READ_BYTES-1:0][7:0] tc_bytes_t;

    // Configuration register set
    typedef struct packed {
        logic [16:0] sec_header_length;
        logic [7:0]  time_code_length;
        logic [3:0]  time_code_format;
    } cfg_t;

    // One result item
    typedef struct packed {
        status_t     status;
        logic        has_secondary;
        logic [15:0] data_length_field;
        logic        time_valid;
        logic [31:0] cuc_coarse;
        logic [23:0] cuc_fine;
        logic        mission_epoch;
        logic [23:0] cds_days;
        logic [31:0] cds_milliseconds;
        logic [15:0] cds_submilliseconds;
        logic        submilli_present;
    } result_t;

endpackage

`default_nettype wire

// File: src/sphc_decode.sv
// ----------------------------------------------------------------------------
// sphc_decode
// Header checks and time code unpacking for one finished packet.
// ----------------------------------------------------------------------------
`default_nettype none

module sphc_decode
(
    input  wire sphc_pkg::cfg_t      cfg,
    input  wire logic [7:0]          first_header_byte,
    input  wire logic [15:0]         length_field,
    input  wire logic [16:0]         total,
    input  wire sphc_pkg::tc_bytes_t tc,
    output sphc_pkg::result_t        result
);
    import sphc_pkg::*;

    always_comb
    begin
        logic        hs;
        logic        sec_on;
        logic [16:0] dl_17;
        logic [1:0]  fo;
        logic [7:0]  need;

        hs     = first_header_byte[SEC_FLAG_BIT];
        sec_on = (cfg.sec_header_length != 17'd0);
        dl_17  = {1'b0, length_field};
        fo     = 2'(cfg.time_code_format - 4'd1);
        need   = 8'd0;

        result = '0;
        result.has_secondary     = hs;
        result.data_length_field = length_field;

        // Check header in priority order
        if (total < HDR_BYTES_17)
        begin
            result.status            = ST_TOO_SMALL;
            result.has_secondary     = 1'b0;
            result.data_length_field = 16'd0;
        end
        else if (total != dl_17 + OVERHEAD_17)
        begin
            result.status = ST_LEN_MISMATCH;
        end
        else if (hs && sec_on && ({9'd0, cfg.time_code_length} > cfg.sec_header_length))
        begin
            result.status = ST_CFG_INVALID;
        end
        else if (hs && sec_on && (cfg.sec_header_length > dl_17 + 17'd1))
        begin
            result.status = ST_SEC_OVERSIZE;
        end
        else
        begin
            result.status = ST_OK;
        end

        // Unpack time code fields for a good packet
        if (result.status == ST_OK && hs && sec_on && cfg.time_code_length != 8'd0)
        begin
            if (cfg.time_code_format inside {[FMT_CUC_FIRST:FMT_CUC_LAST]})
            begin
                need = 8'd4 + {6'd0, fo};
                if (cfg.time_code_length >= need)
                begin
                    result.time_valid    = 1'b1;
                    result.cuc_coarse    = {tc[0], tc[1], tc[2], tc[3]};
                    result.mission_epoch = (cfg.time_code_format >= FMT_CUC_L2);
                    case (fo)
                        2'd0:    result.cuc_fine = 24'd0;
                        2'd1:    result.cuc_fine = {16'd0, tc[4]};
                        2'd2:    result.cuc_fine = {8'd0, tc[4], tc[5]};
                        default: result.cuc_fine = {tc[4], tc[5], tc[6]};
                    endcase
                end
            end
            else if (cfg.time_code_format == FMT_CDS_SHORT)
            begin
                if (cfg.time_code_length >= 8'd6)
                begin
                    result.time_valid       = 1'b1;
                    result.cds_days         = {8'd0, tc[0], tc[1]};
                    result.cds_milliseconds = {tc[2], tc[3], tc[4], tc[5]};
                    if (cfg.time_code_length >= 8'd8)
                    begin
                        result.submilli_present    = 1'b1;
                        result.cds_submilliseconds = {tc[6], tc[7]};
                    end
                end
            end
            else if (cfg.time_code_format == FMT_CDS_LONG)
            begin
                if (cfg.time_code_length >= 8'd7)
                begin
                    result.time_valid       = 1'b1;
                    result.cds_days         = {tc[0], tc[1], tc[2]};
                    result.cds_milliseconds = {tc[3], tc[4], tc[5], tc[6]};
                    if (cfg.time_code_length >= 8'd9)
                    begin
                        result.submilli_present    = 1'b1;
                        result.cds_submilliseconds = {tc[7], tc[8]};
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: src/space_packet_header_checker.sv
// ----------------------------------------------------------------------------
// space_packet_header_checker
// Checks the primary header of a space packet and unpacks its time code.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) takes one packet byte per item,
//   with last_byte set on the final byte. Every byte can be taken in
//   consecutive cycles, so the rate is one byte per clock while not stalled.
//   The output channel (out_valid / out_stall) gives one result item per
//   packet: the status code, header fields and unpacked time fields.
//   After the final byte is accepted, the byte count is first captured into
//   the header registers; the checks then take it into the result register
//   once that register is free.
//   Configuration is written through cfg_we / cfg_index / cfg_data while
//   the block is idle; it is read when a packet's result is formed.
//   Reset clears the configuration, the header registers and the byte
//   count, and empties the result register.
//   While out_stall holds, the result register keeps its item. Bytes keep
//   flowing in until a second finished packet waits behind it; then
//   in_stall is raised until the result register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module space_packet_header_checker
#(
    parameter int TIME_CODE_BYTES = 9
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [16:0] cfg_data,

    // Byte input
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,

    // Result output
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic             has_secondary,
    output logic [15:0]      data_length_field,
    output logic             time_valid,
    output logic [31:0]      cuc_coarse,
    output logic [23:0]      cuc_fine,
    output logic             mission_epoch,
    output logic [23:0]      cds_days,
    output logic [31:0]      cds_milliseconds,
    output logic [15:0]      cds_submilliseconds,
    output logic             submilli_present
);
    import sphc_pkg::*;

    localparam int IDX_W = (TIME_CODE_BYTES > 1) ? $clog2(TIME_CODE_BYTES) : 1;

    cfg_t        cfg_reg;
    logic [7:0]  first_byte_reg;
    logic [15:0] length_reg;
    logic [16:0] count_reg;
    logic [16:0] count_next;
    logic [16:0] total_reg;
    logic        fin_reg;
    logic        out_valid_reg;
    result_t     result_reg;
    result_t     result_next;
    logic [7:0]  tc_store [TIME_CODE_BYTES];
    tc_bytes_t   tc_bytes;

    logic        in_accept;
    logic        advance;
    logic [16:0] tc_offset;
    logic        tc_write;

    // Move a finished packet into the result register when it is free
    assign advance   = fin_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = fin_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    assign count_next = (count_reg != COUNT_MAX) ? count_reg + 17'd1 : count_reg;
    assign tc_offset  = count_reg - HDR_BYTES_17;
    assign tc_write   = (count_reg >= HDR_BYTES_17) &&
                        (tc_offset < 17'(TIME_CODE_BYTES));

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SEC_HEADER_LENGTH: cfg_reg.sec_header_length <= cfg_data;
                CFG_TIME_CODE_LENGTH:  cfg_reg.time_code_length  <= cfg_data[7:0];
                CFG_TIME_CODE_FORMAT:  cfg_reg.time_code_format  <= cfg_data[3:0];
                default:               ;
            endcase
        end
    end

    // Capture header bytes and count the packet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_byte_reg <= 8'd0;
            length_reg     <= 16'd0;
            count_reg      <= 17'd0;
            total_reg      <= 17'd0;
            fin_reg        <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                if (count_reg == 17'd0)
                begin
                    first_byte_reg <= data_byte;
                end
                else if (count_reg == 17'd4)
                begin
                    length_reg[15:8] <= data_byte;
                end
                else if (count_reg == 17'd5)
                begin
                    length_reg[7:0] <= data_byte;
                end

                if (last_byte)
                begin
                    count_reg <= 17'd0;
                    total_reg <= count_next;
                end
                else
                begin
                    count_reg <= count_next;
                end
            end

            if (in_accept && last_byte)
            begin
                fin_reg <= 1'b1;
            end
            else if (advance)
            begin
                fin_reg <= 1'b0;
            end
        end
    end

    // Time code store: secondary header bytes
    always_ff @(posedge clk)
    begin
        if (in_accept && tc_write)
        begin
            tc_store[tc_offset[IDX_W-1:0]] <= data_byte;
        end
    end

    // Bytes beyond the store read as zero
    for (genvar g = 0; g < TC_READ_BYTES; g++)
    begin : g_tc
        if (g < TIME_CODE_BYTES)
        begin : g_on
            assign tc_bytes[g] = tc_store[g];
        end
        else
        begin : g_off
            assign tc_bytes[g] = 8'd0;
        end
    end

    sphc_decode u_decode
    (
        .cfg               (cfg_reg),
        .first_header_byte (first_byte_reg),
        .length_field      (length_reg),
        .total             (total_reg),
        .tc                (tc_bytes),
        .result            (result_next)
    );

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign status              = result_reg.status;
    assign has_secondary       = result_reg.has_secondary;
    assign data_length_field   = result_reg.data_length_field;
    assign time_valid          = result_reg.time_valid;
    assign cuc_coarse          = result_reg.cuc_coarse;
    assign cuc_fine            = result_reg.cuc_fine;
    assign mission_epoch       = result_reg.mission_epoch;
    assign cds_days            = result_reg.cds_days;
    assign cds_milliseconds    = result_reg.cds_milliseconds;
    assign cds_submilliseconds = result_reg.cds_submilliseconds;
    assign submilli_present    = result_reg.submilli_present;

endmodule

`default_nettype wire
